// File: hw/rtl/gpssf_pkg.sv
package gpssf_pkg;

  // Per-channel sync modes
  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_ALIGN  = 2'd1,
    MODE_CHECK  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  localparam int unsigned SAT_COUNT_DEF = 32;
  localparam int unsigned SAT_W         = 5;
  localparam int unsigned WORD_W        = 30;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned WNUM_W        = 4;
  localparam int unsigned TIME_W        = 26;
  localparam int unsigned TOW_W         = 17;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 72;

  localparam logic [7:0]        PREAMBLE      = 8'h8b;
  localparam logic [CNT_W-1:0]  SKIP_BITS     = 9'd270;
  localparam logic [CNT_W-1:0]  WORD_BITS     = 9'd30;
  localparam logic [WORD_W-1:0] HOW_FLIP      = 30'h3fffffc0;
  localparam logic [WNUM_W-1:0] WNUM_HOW_DONE = 4'd2;
  localparam logic [WNUM_W-1:0] WNUM_LAST     = 4'd10;
  localparam logic [TIME_W-1:0] TICKS_PER_TOW = 26'd300;
  // (tow - 1) * 300 + 60 = tow * 300 - 240
  localparam logic [TIME_W-1:0] TOW_OFFSET    = 26'd240;
  localparam logic [TIME_W-1:0] TIME_MAX      = 26'h3ffffff;

  // One channel's state
  typedef struct packed {
    mode_e               mode;
    logic [WORD_W-1:0]   shift;
    logic [CNT_W-1:0]    cnt;
    logic [WNUM_W-1:0]   wnum;
    logic                tlm_bit;
    logic                tvld;
    logic [TIME_W-1:0]   tval;
  } chan_t;

  localparam chan_t CHAN_RESET = '{
    mode:    MODE_SEARCH,
    shift:   '0,
    cnt:     '0,
    wnum:    '0,
    tlm_bit: 1'b0,
    tvld:    1'b0,
    tval:    '0
  };

  // One result word minus the channel number
  typedef struct packed {
    logic                word_valid;
    logic [WORD_W-1:0]   word_data;
    logic [WNUM_W-1:0]   word_index;
    logic                time_valid;
    logic                out_bit;
    logic [TIME_W-1:0]   bit_time;
  } res_t;

endpackage

// File: hw/rtl/gpssf_state_mem.sv
module gpssf_state_mem #(
  parameter int unsigned SAT_COUNT = gpssf_pkg::SAT_COUNT_DEF,
  parameter int unsigned IDX_W     = (SAT_COUNT > 1) ? $clog2(SAT_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  gpssf_pkg::chan_t     wr_data_i,
  output gpssf_pkg::chan_t     rd_data_o
);

  gpssf_pkg::chan_t       mem [SAT_COUNT];
  logic [SAT_COUNT-1:0]   written_q;
  gpssf_pkg::chan_t       rd_data_q;
  logic                   rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // Read with bypass of a same-cycle write to the same entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_idx_i] || (wr_en_i && (wr_idx_i == rd_idx_i));
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : gpssf_pkg::CHAN_RESET;

endmodule

// File: hw/rtl/gpssf_step.sv
module gpssf_step (
  input  gpssf_pkg::chan_t  cur_i,
  input  logic              bit_i,
  output gpssf_pkg::chan_t  nxt_o,
  output gpssf_pkg::res_t   res_o
);

  logic [gpssf_pkg::WORD_W-1:0] w;
  logic [gpssf_pkg::WORD_W-1:0] how;
  logic [gpssf_pkg::CNT_W-1:0]  cnt1;
  logic [gpssf_pkg::WNUM_W-1:0] wn1;
  logic [gpssf_pkg::TOW_W-1:0]  tow;
  logic [gpssf_pkg::TIME_W-1:0] tow_ticks;
  logic                         pre;
  gpssf_pkg::chan_t             ns;

  assign w    = {cur_i.shift[gpssf_pkg::WORD_W-2:0], bit_i};
  assign pre  = (w[29:22] == gpssf_pkg::PREAMBLE) || (w[29:22] == ~gpssf_pkg::PREAMBLE);
  assign cnt1 = cur_i.cnt + 1'b1;
  assign wn1  = cur_i.wnum + 1'b1;
  assign how  = cur_i.tlm_bit ? (w ^ gpssf_pkg::HOW_FLIP) : w;
  assign tow  = how[29:13];
  assign tow_ticks = gpssf_pkg::TIME_W'(tow) * gpssf_pkg::TICKS_PER_TOW
                     - gpssf_pkg::TOW_OFFSET;

  always_comb begin
    ns    = cur_i;
    res_o = '0;
    unique case (cur_i.mode)
      gpssf_pkg::MODE_SEARCH: begin
        ns.shift = w;
        if (pre) begin
          ns.mode = gpssf_pkg::MODE_ALIGN;
          ns.cnt  = '0;
          ns.tvld = 1'b0;
        end
      end
      gpssf_pkg::MODE_ALIGN: begin
        ns.cnt = cnt1;
        if (cnt1 == gpssf_pkg::SKIP_BITS) begin
          ns.mode  = gpssf_pkg::MODE_CHECK;
          ns.shift = '0;
          ns.cnt   = '0;
        end
      end
      gpssf_pkg::MODE_CHECK: begin
        ns.shift = w;
        ns.cnt   = cnt1;
        if (cnt1 == gpssf_pkg::WORD_BITS) begin
          ns.shift = '0;
          if (pre) begin
            res_o.word_valid = 1'b1;
            res_o.word_data  = w;
            ns.mode    = gpssf_pkg::MODE_READ;
            ns.tlm_bit = w[0];
            ns.cnt     = '0;
            ns.wnum    = gpssf_pkg::WNUM_W'(1);
          end else begin
            ns.mode = gpssf_pkg::MODE_SEARCH;
            ns.tvld = 1'b0;
          end
        end
      end
      gpssf_pkg::MODE_READ: begin
        ns.shift = w;
        ns.cnt   = cnt1;
        if (cnt1 == gpssf_pkg::WORD_BITS) begin
          res_o.word_valid = 1'b1;
          res_o.word_data  = w;
          res_o.word_index = cur_i.wnum;
          ns.wnum  = wn1;
          ns.shift = '0;
          ns.cnt   = '0;
          if (wn1 == gpssf_pkg::WNUM_HOW_DONE) begin
            // zero tow gives a negative time: leave time invalid
            ns.tvld = (tow != '0);
            ns.tval = tow_ticks;
          end
          if (wn1 == gpssf_pkg::WNUM_LAST) begin
            ns.mode = gpssf_pkg::MODE_CHECK;
          end
        end
      end
      default: ;
    endcase

    // Stamp the bit with the current time, then advance with saturation
    if (ns.tvld) begin
      res_o.time_valid = 1'b1;
      res_o.out_bit    = bit_i;
      res_o.bit_time   = ns.tval;
      if (ns.tval != gpssf_pkg::TIME_MAX) begin
        ns.tval = ns.tval + 1'b1;
      end
    end
  end

  assign nxt_o = ns;

endmodule

// File: hw/rtl/gps_nav_subframe_sync.sv
// GPS nav subframe synchronizer, one independent channel per satellite.
// Input stream (s_axis_*): one word per demodulated nav bit, tagged with
// its satellite channel. Output stream (m_axis_*): exactly one word per
// input word, in order: the channel, a completed 30-bit nav word with its
// index in the subframe (0 is TLM) when one ends on this bit, and the bit
// echoed with its GPS time in 20 ms ticks once the HOW has been decoded.
// Channels at or above SAT_COUNT are ignored and return only their number.
// An accepted word is registered in stage A while its channel state is
// read, then in the output register. Throughput: one word per cycle
// sustained while the receiver does not stall, any mix of channels.
// Channel state lives in a SAT_COUNT-entry memory with a registered read;
// back-to-back words on the same channel are served by a write-to-read
// bypass, so the single read-modify-write per word sets the rate. Reset
// clears all pipeline valids and the per-entry written flags; every
// channel then reads as search mode with no valid time. When the receiver
// stalls, the output register holds its word, the staged word waits behind
// it and s_axis_tready_o drops only once both are full.
module gps_nav_subframe_sync #(
  parameter int unsigned SAT_COUNT = gpssf_pkg::SAT_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [4:0] sat, [5] bit_value, [7:6] zero
  input  logic [gpssf_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [4:0] out_sat, [5] word_valid, [35:6] word_data, [39:36] word_index,
  // [40] time_valid, [41] out_bit, [67:42] bit_time, [71:68] zero
  output logic [gpssf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned IDX_W = (SAT_COUNT > 1) ? $clog2(SAT_COUNT) : 1;

  logic [gpssf_pkg::SAT_W-1:0] in_sat;
  logic                        in_bit;
  logic                        in_range;
  logic                        in_acc;
  logic                        adv;
  logic                        wr_en;

  // Stage A: staged input word, channel state read in flight
  logic                        a_valid_q;
  logic [gpssf_pkg::SAT_W-1:0] a_sat_q;
  logic                        a_bit_q;
  logic                        a_inr_q;

  // Output register
  logic                                 o_valid_q;
  logic [gpssf_pkg::OUT_TDATA_W-1:0]    o_data_q;
  logic [gpssf_pkg::OUT_TDATA_W-1:0]    o_data_d;

  gpssf_pkg::chan_t cur_st;
  gpssf_pkg::chan_t nxt_st;
  gpssf_pkg::res_t  res;

  assign in_sat   = s_axis_tdata_i[gpssf_pkg::SAT_W-1:0];
  assign in_bit   = s_axis_tdata_i[gpssf_pkg::SAT_W];
  assign in_range = (32'(in_sat) < SAT_COUNT);

  // Advance stage A into the output register when it is free or draining
  assign adv             = !o_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !a_valid_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = a_valid_q && adv && a_inr_q;

  gpssf_state_mem #(
    .SAT_COUNT (SAT_COUNT),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc && in_range),
    .rd_idx_i  (IDX_W'(in_sat)),
    .wr_en_i   (wr_en),
    .wr_idx_i  (IDX_W'(a_sat_q)),
    .wr_data_i (nxt_st),
    .rd_data_o (cur_st)
  );

  gpssf_step u_step (
    .cur_i (cur_st),
    .bit_i (a_bit_q),
    .nxt_o (nxt_st),
    .res_o (res)
  );

  // Out-of-range channels carry only their number
  always_comb begin
    o_data_d = '0;
    o_data_d[4:0] = a_sat_q;
    if (a_inr_q) begin
      o_data_d[5]     = res.word_valid;
      o_data_d[35:6]  = res.word_data;
      o_data_d[39:36] = res.word_index;
      o_data_d[40]    = res.time_valid;
      o_data_d[41]    = res.out_bit;
      o_data_d[67:42] = res.bit_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        a_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_sat_q <= in_sat;
      a_bit_q <= in_bit;
      a_inr_q <= in_range;
    end
    if (adv && a_valid_q) begin
      o_data_q <= o_data_d;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_data_q;

  // Word index stays within the ten words of a subframe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[5]) |-> (m_axis_tdata_o[39:36] <= 4'd9))
    else $error("word index beyond subframe");

  // No word payload without word_valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[5]) |->
      (m_axis_tdata_o[39:6] == '0))
    else $error("word fields set without word_valid");

  // No time payload without time_valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[40]) |->
      (m_axis_tdata_o[67:41] == '0))
    else $error("time fields set without time_valid");

  // A staged word never loses its slot while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !adv) |=> (a_valid_q && $stable(a_sat_q)))
    else $error("staged word lost during stall");

endmodule

// File: tb/gps_nav_sync_checker.sv
module gps_nav_sync_checker #(
  parameter int unsigned CHANNELS = gpssf_pkg::SAT_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  // [4:0] sat, [5] bit_value, [7:6] zero
  input  logic [gpssf_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  // [4:0] out_sat, [5] word_valid, [35:6] word_data, [39:36] word_index,
  // [40] time_valid, [41] out_bit, [67:42] bit_time, [71:68] zero
  input  logic [gpssf_pkg::OUT_TDATA_W-1:0]   m_tdata_i,
  output int                                  mismatches_o,
  output int                                  words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]                   SYNC_PATTERN = 8'h8b;
  localparam logic [gpssf_pkg::CNT_W-1:0]  SKIP_LEN     = 9'd270;
  localparam logic [gpssf_pkg::CNT_W-1:0]  WORD_LEN     = 9'd30;
  localparam logic [gpssf_pkg::WORD_W-1:0] HOW_INVERT   = 30'h3fffffc0;
  localparam logic [gpssf_pkg::WNUM_W-1:0] HOW_NEXT     = 4'd2;
  localparam logic [gpssf_pkg::WNUM_W-1:0] FRAME_END    = 4'd10;
  localparam logic [31:0]                  TOW_TICKS    = 32'd300;
  localparam logic [31:0]                  FIRST_OFFSET = 32'd60;
  localparam logic [31:0]                  TICK_CAP     = 32'd67108863;
  localparam logic [31:0]                  TICKS_NONE   = 32'hffffffff;
  localparam int                           PRINT_CAP    = 200;

  typedef struct packed {
    logic [gpssf_pkg::SAT_W-1:0] sat;
    gpssf_pkg::res_t             res;
  } sync_word_t;

  // Per-channel sync state
  gpssf_pkg::mode_e             mode_q  [CHANNELS];
  logic [gpssf_pkg::WORD_W-1:0] shift_q [CHANNELS];
  logic [gpssf_pkg::CNT_W-1:0]  cnt_q   [CHANNELS];
  logic [gpssf_pkg::WNUM_W-1:0] wnum_q  [CHANNELS];
  logic                         tlm_q   [CHANNELS];
  logic [31:0]                  ticks_q [CHANNELS];

  sync_word_t words_due_q[$];

  function automatic logic has_preamble(input logic [gpssf_pkg::WORD_W-1:0] w);
    return (w[29:22] == SYNC_PATTERN) || (~w[29:22] == SYNC_PATTERN);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches_o < PRINT_CAP)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches_o = mismatches_o + 1;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // Advance one channel by one nav bit and build the word it must return.
  task automatic advance_channel(input logic [gpssf_pkg::SAT_W-1:0] sat,
                                 input logic nav_bit, output sync_word_t due);
    logic [gpssf_pkg::WORD_W-1:0] w;
    logic [gpssf_pkg::WORD_W-1:0] how;
    logic [gpssf_pkg::TOW_W-1:0]  tow;
    logic [31:0]                  t;
    due = '0;
    due.sat = sat;
    if (sat < CHANNELS) begin
      w = {shift_q[sat][gpssf_pkg::WORD_W-2:0], nav_bit};
      case (mode_q[sat])
        gpssf_pkg::MODE_SEARCH: begin
          shift_q[sat] = w;
          if (has_preamble(w)) begin
            mode_q[sat]  = gpssf_pkg::MODE_ALIGN;
            cnt_q[sat]   = '0;
            ticks_q[sat] = TICKS_NONE;
          end
        end
        gpssf_pkg::MODE_ALIGN: begin
          cnt_q[sat] = cnt_q[sat] + 1'b1;
          if (cnt_q[sat] == SKIP_LEN) begin
            mode_q[sat]  = gpssf_pkg::MODE_CHECK;
            shift_q[sat] = '0;
            cnt_q[sat]   = '0;
          end
        end
        gpssf_pkg::MODE_CHECK: begin
          shift_q[sat] = w;
          cnt_q[sat]   = cnt_q[sat] + 1'b1;
          if (cnt_q[sat] == WORD_LEN) begin
            shift_q[sat] = '0;
            cnt_q[sat]   = '0;
            if (has_preamble(w)) begin
              due.res.word_valid = 1'b1;
              due.res.word_data  = w;
              due.res.word_index = '0;
              mode_q[sat] = gpssf_pkg::MODE_READ;
              tlm_q[sat]  = w[0];
              wnum_q[sat] = 4'd1;
            end else begin
              // lost lock: drop the time and hunt again
              mode_q[sat]  = gpssf_pkg::MODE_SEARCH;
              ticks_q[sat] = TICKS_NONE;
            end
          end
        end
        default: begin
          shift_q[sat] = w;
          cnt_q[sat]   = cnt_q[sat] + 1'b1;
          if (cnt_q[sat] == WORD_LEN) begin
            due.res.word_valid = 1'b1;
            due.res.word_data  = w;
            due.res.word_index = wnum_q[sat];
            wnum_q[sat] = wnum_q[sat] + 1'b1;
            if (wnum_q[sat] == HOW_NEXT) begin
              how = tlm_q[sat] ? (w ^ HOW_INVERT) : w;
              tow = how[29:13];
              ticks_q[sat] = (32'(tow) - 32'd1) * TOW_TICKS + FIRST_OFFSET;
            end
            shift_q[sat] = '0;
            cnt_q[sat]   = '0;
            if (wnum_q[sat] == FRAME_END)
              mode_q[sat] = gpssf_pkg::MODE_CHECK;
          end
        end
      endcase
      t = ticks_q[sat];
      if (t != 32'd0 && !t[31]) begin
        due.res.time_valid = 1'b1;
        due.res.out_bit    = nav_bit;
        due.res.bit_time   = t[gpssf_pkg::TIME_W-1:0];
        if (t < TICK_CAP)
          ticks_q[sat] = t + 32'd1;
      end
    end
  endtask

  // Sample at the falling edge: a handshake seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    sync_word_t due;
    sync_word_t oldest;
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mode_q[c]  = gpssf_pkg::MODE_SEARCH;
        shift_q[c] = '0;
        cnt_q[c]   = '0;
        wnum_q[c]  = '0;
        tlm_q[c]   = 1'b0;
        ticks_q[c] = TICKS_NONE;
      end
      words_due_q.delete();
      mismatches_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (words_due_q.size() == 0) begin
          report_mismatch("word with nothing due, channel", 32'(m_tdata_i[4:0]), 32'd0);
        end else begin
          oldest = words_due_q.pop_front();
          check_field("out_sat",    32'(m_tdata_i[4:0]),   32'(oldest.sat));
          check_field("word_valid", 32'(m_tdata_i[5]),     32'(oldest.res.word_valid));
          check_field("word_data",  32'(m_tdata_i[35:6]),  32'(oldest.res.word_data));
          check_field("word_index", 32'(m_tdata_i[39:36]), 32'(oldest.res.word_index));
          check_field("time_valid", 32'(m_tdata_i[40]),    32'(oldest.res.time_valid));
          check_field("out_bit",    32'(m_tdata_i[41]),    32'(oldest.res.out_bit));
          check_field("bit_time",   32'(m_tdata_i[67:42]), 32'(oldest.res.bit_time));
          check_field("pad",        32'(m_tdata_i[71:68]), 32'd0);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_channel(s_tdata_i[4:0], s_tdata_i[5], due);
        words_due_q.push_back(due);
      end
    end
    words_due_o = words_due_q.size();
  end

endmodule

// File: tb/tb_gps_nav_subframe_sync.sv
module tb_gps_nav_subframe_sync;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 35;    // chance in a hundred that a side idles
  localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving before giving up
  localparam int DRAIN_CYCLES = 8;     // drain margin after the last due word
  localparam int NOISE_PCT    = 8;     // chance in a hundred of a stray bit to another channel
  localparam int FRAMES       = 3;     // lock, then two checked subframes
  localparam int LEAD_MAX     = 40;    // longest random lead-in
  localparam int LANE_MAX     = LEAD_MAX + FRAMES * 300;
  localparam int CALM_FROM    = 300;   // busy stretch with no idling, in words sent
  localparam int CALM_TO      = 650;
  localparam logic [7:0] SYNC_PATTERN = 8'h8b;

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [71:0] m_tdata;
  logic       calm;          // hold both sides busy while set
  int         mismatches;
  int         words_due;
  int         quiet_cycles;

  // Framed bit stream for the locked channel, sent oldest bit first
  logic       lane_bits [LANE_MAX];
  int         lane_len;
  int         lane_pos;
  logic [4:0] lane_sat;

  gps_nav_subframe_sync dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  gps_nav_sync_checker sync_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  always #10 clk = ~clk;

  // Receiver: stall at random, never while calm is set.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(negedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one nav bit, idling first at random, and hold it until taken.
  task automatic send_nav_bit(input logic [4:0] sat, input logic nav_bit);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, nav_bit, sat};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_bit(input logic b);
    lane_bits[lane_len] = b;
    lane_len = lane_len + 1;
  endtask

  // Append a 30-bit word, its top bit on the air first.
  task automatic append_word(input logic [29:0] w);
    for (int i = 29; i >= 0; i--)
      push_bit(w[i]);
  endtask

  // Append one 300-bit subframe as received: TLM, HOW, eight data words.
  // The HOW is built so that the tow the block decodes is the one picked
  // here, whatever the polarity and the last TLM bit.
  task automatic add_frame(input logic inverted, input logic broken);
    logic [29:0] tlm;
    logic [29:0] how;
    logic [16:0] tow;
    tlm = 30'($urandom);
    tlm[29:22] = inverted ? ~SYNC_PATTERN : SYNC_PATTERN;
    if (broken)
      tlm = tlm ^ (30'd1 << (22 + $urandom_range(7)));
    case ($urandom_range(9))
      0, 1:    tow = '0;       // zero tow: bits go out without time
      2:       tow = '1;       // largest tow
      3:       tow = 17'd1;
      default: tow = 17'($urandom);
    endcase
    how = 30'($urandom);
    how[29:13] = tlm[0] ? ~tow : tow;
    append_word(tlm);
    append_word(how);
    repeat (8) append_word(30'($urandom));
  endtask

  initial begin
    int   sent;
    logic inverted;
    logic [4:0] noise_sat;

    clk      = 1'b0;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    calm     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners: lowest and highest channel with both bit values, then every
    // channel bit alone (bit value 1) and cleared alone (bit value 0). Every
    // 5-bit channel is in range, so none of these is ignored.
    send_nav_bit(5'd0, 1'b1);
    send_nav_bit(5'd0, 1'b0);
    send_nav_bit(5'd31, 1'b1);
    send_nav_bit(5'd31, 1'b0);
    for (int k = 0; k < 5; k++) begin
      send_nav_bit(5'd1 << k, 1'b1);
      send_nav_bit(~(5'd1 << k), 1'b0);
    end

    // Framed traffic: one channel gets a random lead-in and FRAMES subframes,
    // some with a broken preamble, maybe inverted, with stray bits to other
    // channels mixed in at random. The bit time cap lies beyond any tow plus
    // the bits a run can send.
    lane_len = 0;
    lane_pos = 0;
    inverted = 1'($urandom_range(1));
    repeat ($urandom_range(LEAD_MAX)) push_bit(1'($urandom_range(1)));
    repeat (FRAMES) add_frame(inverted, $urandom_range(7) == 0);
    lane_sat = 5'($urandom);
    sent = 0;
    while (lane_pos < lane_len) begin
      // Hold both sides busy through a long stretch in the middle.
      calm <= (sent >= CALM_FROM) && (sent < CALM_TO);
      if ($urandom_range(99) < NOISE_PCT) begin
        do noise_sat = 5'($urandom);
        while (noise_sat == lane_sat);
        send_nav_bit(noise_sat, 1'($urandom_range(1)));
      end else begin
        send_nav_bit(lane_sat, lane_bits[lane_pos]);
        lane_pos = lane_pos + 1;
      end
      sent = sent + 1;
    end

    // Drop valid, drain every due word, then give the pipe a few more cycles.
    s_tvalid <= 1'b0;
    calm     <= 1'b0;
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_due == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/gpssf_pkg.sv
hw/rtl/gpssf_state_mem.sv
hw/rtl/gpssf_step.sv
hw/rtl/gps_nav_subframe_sync.sv
tb/gps_nav_sync_checker.sv
tb/tb_gps_nav_subframe_sync.sv
